// ===== src/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants for the tagged record scanner.
// ----------------------------------------------------------------------------
package trs_pkg;

  localparam int unsigned WinLen = 16;

  // byte counts of the record layout
  localparam logic [4:0] HEADER_LEN = 5'd4;
  localparam logic [4:0] WIN_BYTES  = 5'd16;
  localparam logic [4:0] GUID_SKIP  = 5'd16;
  localparam logic [4:0] NAME_SKIP  = 5'd8;
  localparam logic [4:0] LEN_LAST   = 5'd3;

  // window offsets that carry tag bytes
  localparam int unsigned TagPosA = 0;
  localparam int unsigned TagPosB = 8;

  // result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_GUID_TAG   = 3'd0;
  localparam logic [2:0] REG_STRUCT_TAG = 3'd1;
  localparam logic [2:0] REG_NAME_TAG   = 3'd2;
  localparam logic [2:0] REG_STRING_TAG = 3'd3;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_FILL   = 4'd1,
    PH_SCAN   = 4'd2,
    PH_GSKIP  = 4'd3,
    PH_GWORD  = 4'd4,
    PH_NSKIP  = 4'd5,
    PH_NLEN   = 4'd6,
    PH_NCHAR  = 4'd7,
    PH_NEND   = 4'd8
  } phase_t;

  // per-cell compare result against both signatures
  typedef struct packed {
    logic guid;
    logic name;
  } cell_hit_t;

endpackage

// ===== src/trs_byte_if.sv =====
// ----------------------------------------------------------------------------
// trs_byte_if
// Byte stream channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface trs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== src/trs_rec_if.sv =====
// ----------------------------------------------------------------------------
// trs_rec_if
// Result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface trs_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] value;
  logic [1:0]  word_index;
  logic        last;

  modport source (output valid, output kind, output value, output word_index,
                  output last, input ready);
  modport sink   (input valid, input kind, input value, input word_index,
                  input last, output ready);
endinterface

// ===== src/trs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// trs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface trs_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/trs_cell.sv =====
// ----------------------------------------------------------------------------
// trs_cell
// One window byte: shifts in from its neighbor and compares with both
// signature bytes expected at its offset.
// ----------------------------------------------------------------------------
module trs_cell import trs_pkg::*; (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  input  logic [7:0] want_guid,
  input  logic [7:0] want_name,
  output logic [7:0] dout,
  output cell_hit_t  hit
);

  logic [7:0] data;

  // byte storage, moves toward offset zero on each shift
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din;
    end
  end

  assign dout     = data;
  assign hit.guid = (data == want_guid);
  assign hit.name = (data == want_name);

endmodule

// ===== src/tagged_record_scanner.sv =====
// A result is registered and shown in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the 16-cell window chain compares in the
// same cycle as the phase machine steps, and the output register frees the
// input side whenever the result is taken.
// Reset: phase returns to header discard, tag registers clear to zero, the
// output register empties; the window needs no clear, it is filled first.
// ----------------------------------------------------------------------------
// tagged_record_scanner
// Scans a byte stream for identifier and name signatures and extracts
// identifier words and name characters.
// ----------------------------------------------------------------------------
module tagged_record_scanner import trs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  trs_byte_if.sink   stream,
  trs_rec_if.source  records,
  trs_cfg_if.sink    cfg
);

  // tag registers
  logic [7:0] guid_tag;
  logic [7:0] struct_tag;
  logic [7:0] name_tag;
  logic [7:0] string_tag;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      guid_tag   <= '0;
      struct_tag <= '0;
      name_tag   <= '0;
      string_tag <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GUID_TAG:   guid_tag   <= cfg.data;
        REG_STRUCT_TAG: struct_tag <= cfg.data;
        REG_NAME_TAG:   name_tag   <= cfg.data;
        REG_STRING_TAG: string_tag <= cfg.data;
        default: ;
      endcase
    end
  end

  // output register and input handshake
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_value;
  logic [1:0]  out_word_index;
  logic        out_last;
  logic        accept;

  assign stream.ready = !out_valid || records.ready;
  assign accept       = stream.valid && stream.ready;

  // window cell chain
  logic [7:0] cell_byte [WinLen];
  cell_hit_t  cell_hit  [WinLen];
  logic       win_shift;
  logic [WinLen-1:0] guid_bits;
  logic [WinLen-1:0] name_bits;
  logic       guid_match;
  logic       name_match;

  for (genvar i = 0; i < WinLen; i++) begin : g_cell
    logic [7:0] din;
    logic [7:0] want_guid;
    logic [7:0] want_name;

    if (i == WinLen - 1) begin : g_tail
      assign din = stream.in_byte;
    end else begin : g_link
      assign din = cell_byte[i+1];
    end

    if (i == TagPosA) begin : g_tag_a
      assign want_guid = guid_tag;
      assign want_name = name_tag;
    end else if (i == TagPosB) begin : g_tag_b
      assign want_guid = struct_tag;
      assign want_name = string_tag;
    end else begin : g_zero
      assign want_guid = 8'd0;
      assign want_name = 8'd0;
    end

    trs_cell u_cell (
      .clk       (clk),
      .shift     (win_shift),
      .din       (din),
      .want_guid (want_guid),
      .want_name (want_name),
      .dout      (cell_byte[i]),
      .hit       (cell_hit[i])
    );

    assign guid_bits[i] = cell_hit[i].guid;
    assign name_bits[i] = cell_hit[i].name;
  end

  assign guid_match = &guid_bits;
  assign name_match = &name_bits;

  // phase machine state
  phase_t      phase,         phase_next;
  logic [4:0]  byte_count,    byte_count_next;
  logic [31:0] name_length,   name_length_next;
  logic [23:0] word_assembly, word_assembly_next;
  logic [1:0]  word_number,   word_number_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_count    <= '0;
      name_length   <= '0;
      word_assembly <= '0;
      word_number   <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      name_length   <= name_length_next;
      word_assembly <= word_assembly_next;
      word_number   <= word_number_next;
    end
  end

  // next state and result for the current byte
  logic        emit;
  logic [1:0]  emit_kind;
  logic [31:0] emit_value;
  logic [1:0]  emit_word_index;
  logic        emit_last;
  logic [4:0]  count_inc;
  logic [31:0] len_full;
  logic [31:0] len_dec;
  logic        shift_req;

  assign count_inc = byte_count + 5'd1;

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    name_length_next   = name_length;
    word_assembly_next = word_assembly;
    word_number_next   = word_number;
    emit               = 1'b0;
    emit_kind          = KIND_CHAR;
    emit_value         = '0;
    emit_word_index    = 2'd0;
    emit_last          = 1'b0;
    shift_req          = 1'b0;
    len_full           = {stream.in_byte, name_length[23:0]};
    len_dec            = name_length - 32'd1;

    case (phase)
      PH_HEADER: begin
        byte_count_next = count_inc;
        if (count_inc >= HEADER_LEN) begin
          phase_next      = PH_FILL;
          byte_count_next = '0;
        end
      end
      PH_FILL: begin
        shift_req       = 1'b1;
        byte_count_next = count_inc;
        if (count_inc >= WIN_BYTES) begin
          phase_next      = PH_SCAN;
          byte_count_next = '0;
        end
      end
      PH_SCAN: begin
        if (guid_match) begin
          phase_next      = PH_GSKIP;
          byte_count_next = 5'd1;
        end else if (name_match) begin
          phase_next      = PH_NSKIP;
          byte_count_next = 5'd1;
        end else begin
          shift_req = 1'b1;
        end
      end
      PH_GSKIP: begin
        byte_count_next = count_inc;
        if (count_inc >= GUID_SKIP) begin
          phase_next         = PH_GWORD;
          byte_count_next    = '0;
          word_number_next   = '0;
          word_assembly_next = '0;
        end
      end
      PH_GWORD: begin
        if (byte_count < LEN_LAST) begin
          case (byte_count[1:0])
            2'd0:    word_assembly_next[7:0]   = stream.in_byte;
            2'd1:    word_assembly_next[15:8]  = stream.in_byte;
            default: word_assembly_next[23:16] = stream.in_byte;
          endcase
          byte_count_next = count_inc;
        end else begin
          emit               = 1'b1;
          emit_kind          = KIND_WORD;
          emit_value         = {stream.in_byte, word_assembly};
          emit_word_index    = word_number;
          emit_last          = (word_number == 2'd3);
          word_assembly_next = '0;
          byte_count_next    = '0;
          word_number_next   = word_number + 2'd1;
          if (word_number == 2'd3) begin
            phase_next = PH_FILL;
          end
        end
      end
      PH_NSKIP: begin
        byte_count_next = count_inc;
        if (count_inc >= NAME_SKIP) begin
          phase_next       = PH_NLEN;
          byte_count_next  = '0;
          name_length_next = '0;
        end
      end
      PH_NLEN: begin
        byte_count_next = count_inc;
        case (byte_count[1:0])
          2'd0:    name_length_next[7:0]   = stream.in_byte;
          2'd1:    name_length_next[15:8]  = stream.in_byte;
          2'd2:    name_length_next[23:16] = stream.in_byte;
          default: name_length_next[31:24] = stream.in_byte;
        endcase
        if (byte_count >= LEN_LAST) begin
          byte_count_next = '0;
          // zero length counts as one
          if (len_full <= 32'd1) begin
            name_length_next = '0;
            phase_next       = PH_NEND;
          end else begin
            name_length_next = len_full - 32'd1;
            phase_next       = PH_NCHAR;
          end
        end
      end
      PH_NCHAR: begin
        name_length_next = len_dec;
        if (len_dec == 32'd0) begin
          phase_next = PH_NEND;
        end
        emit       = 1'b1;
        emit_kind  = KIND_CHAR;
        emit_value = {24'd0, stream.in_byte};
      end
      PH_NEND: begin
        phase_next      = PH_FILL;
        byte_count_next = '0;
        emit            = 1'b1;
        emit_kind       = KIND_END;
        emit_last       = 1'b1;
      end
      default: begin
        phase_next      = PH_FILL;
        byte_count_next = '0;
      end
    endcase
  end

  assign win_shift = accept && shift_req;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (records.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind       <= emit_kind;
      out_value      <= emit_value;
      out_word_index <= emit_word_index;
      out_last       <= emit_last;
    end
  end

  assign records.valid      = out_valid;
  assign records.kind       = out_kind;
  assign records.value      = out_value;
  assign records.word_index = out_word_index;
  assign records.last       = out_last;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tagged record scanner. Byte streams are built
// from well-formed identifier and name records, broken signatures and noise.
// A cycle-free model of the scanner, stepped on every accepted request,
// predicts the records, and these are compared in order with what the block
// delivers. Tag registers are rewritten between phases while the block is
// idle. The sender runs in bursts and the receiver stalls, once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb import trs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         IdleLimit      = 2000;
  localparam int         SettleCycles   = 6;
  localparam int         PhaseBudget    = 270;
  localparam int         HoldAfterBytes = 700;
  localparam int         HoldCycles     = 300;
  localparam logic [4:0] WordLastByte   = 5'd3;
  localparam logic [4:0] LenBytes       = LEN_LAST + 5'd1;
  localparam logic [1:0] LastWord       = 2'd3;
  localparam logic [2:0] RegFirstUnused = REG_STRING_TAG + 3'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [1:0]  word_index;
    logic        last;
  } record_t;

  logic clk;
  logic rst;

  trs_byte_if stream_if ();
  trs_rec_if  rec_if ();
  trs_cfg_if  cfg_if ();

  tagged_record_scanner i_dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_if),
    .records (rec_if),
    .cfg     (cfg_if)
  );

  // tag registers as the block should hold them
  logic [7:0] tag_guid;
  logic [7:0] tag_struct;
  logic [7:0] tag_name;
  logic [7:0] tag_string;

  // scanner state as predicted
  phase_t      scan_phase;
  logic [4:0]  scan_count;
  logic [7:0]  scan_window [WinLen];
  logic [31:0] name_left;
  logic [23:0] word_acc;
  logic [1:0]  word_pos;

  logic [7:0] stream_bytes [$];
  record_t    expected_records [$];

  int pushed_total;
  int check_errors;
  int bytes_accepted;
  int idle_cycles;
  int gap_left;
  int burst_left;
  int stall_left;
  int run_left;
  int hold_left;
  bit hold_done;
  record_t got_rec;
  record_t want_rec;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // scanner model
  // ---------------------------------------------------------------------------
  function automatic bit window_matches(input logic [7:0] first, input logic [7:0] second);
    logic [7:0] want;
    for (int i = 0; i < WinLen; i++) begin
      want = (i == TagPosA) ? first : ((i == TagPosB) ? second : 8'h00);
      if (scan_window[i] !== want) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic step_scanner(input logic [7:0] b);
    record_t rec;
    case (scan_phase)
      PH_HEADER: begin
        scan_count = scan_count + 5'd1;
        if (scan_count >= HEADER_LEN) begin
          scan_phase = PH_FILL;
          scan_count = '0;
        end
      end
      PH_FILL: begin
        scan_window[scan_count[3:0]] = b;
        scan_count = scan_count + 5'd1;
        if (scan_count >= WIN_BYTES) begin
          scan_phase = PH_SCAN;
          scan_count = '0;
        end
      end
      PH_SCAN: begin
        // identifier wins when both signatures are equal
        if (window_matches(tag_guid, tag_struct)) begin
          scan_phase = PH_GSKIP;
          scan_count = 5'd1;
        end else if (window_matches(tag_name, tag_string)) begin
          scan_phase = PH_NSKIP;
          scan_count = 5'd1;
        end else begin
          for (int i = 0; i < WinLen - 1; i++) scan_window[i] = scan_window[i + 1];
          scan_window[WinLen - 1] = b;
        end
      end
      PH_GSKIP: begin
        scan_count = scan_count + 5'd1;
        if (scan_count >= GUID_SKIP) begin
          scan_phase = PH_GWORD;
          scan_count = '0;
          word_pos   = '0;
          word_acc   = '0;
        end
      end
      PH_GWORD: begin
        if (scan_count < WordLastByte) begin
          word_acc   = word_acc | (24'(b) << (8 * scan_count[1:0]));
          scan_count = scan_count + 5'd1;
        end else begin
          rec.kind       = KIND_WORD;
          rec.value      = {b, word_acc};
          rec.word_index = word_pos;
          rec.last       = (word_pos == LastWord);
          expected_records.push_back(rec);
          word_acc   = '0;
          scan_count = '0;
          if (word_pos == LastWord) begin
            word_pos   = '0;
            scan_phase = PH_FILL;
          end else begin
            word_pos = word_pos + 2'd1;
          end
        end
      end
      PH_NSKIP: begin
        scan_count = scan_count + 5'd1;
        if (scan_count >= NAME_SKIP) begin
          scan_phase = PH_NLEN;
          scan_count = '0;
          name_left  = '0;
        end
      end
      PH_NLEN: begin
        name_left  = name_left | (32'(b) << (8 * scan_count[1:0]));
        scan_count = scan_count + 5'd1;
        if (scan_count >= LenBytes) begin
          scan_count = '0;
          // zero length counts as one
          if (name_left == '0) name_left = 32'd1;
          name_left  = name_left - 32'd1;
          scan_phase = (name_left == '0) ? PH_NEND : PH_NCHAR;
        end
      end
      PH_NCHAR: begin
        name_left = name_left - 32'd1;
        if (name_left == '0) scan_phase = PH_NEND;
        rec.kind       = KIND_CHAR;
        rec.value      = 32'(b);
        rec.word_index = '0;
        rec.last       = 1'b0;
        expected_records.push_back(rec);
      end
      PH_NEND: begin
        scan_phase     = PH_FILL;
        scan_count     = '0;
        rec.kind       = KIND_END;
        rec.value      = '0;
        rec.word_index = '0;
        rec.last       = 1'b1;
        expected_records.push_back(rec);
      end
      default: begin
        scan_phase = PH_FILL;
        scan_count = '0;
      end
    endcase
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      REG_GUID_TAG:   tag_guid   = val;
      REG_STRUCT_TAG: tag_struct = val;
      REG_NAME_TAG:   tag_name   = val;
      REG_STRING_TAG: tag_string = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stream building
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    pushed_total++;
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_byte(8'($urandom));
  endtask

  task automatic push_signature(input logic [7:0] first, input logic [7:0] second,
                                input bit broken);
    logic [7:0] sig [WinLen];
    int         pos;
    for (int i = 0; i < WinLen; i++)
      sig[i] = (i == TagPosA) ? first : ((i == TagPosB) ? second : 8'h00);
    if (broken) begin
      pos      = $urandom_range(0, WinLen - 1);
      sig[pos] = sig[pos] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < WinLen; i++) push_byte(sig[i]);
  endtask

  task automatic push_word_le(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8 * i +: 8]);
  endtask

  task automatic push_guid_record(input logic [31:0] w0, input logic [31:0] w1,
                                  input logic [31:0] w2, input logic [31:0] w3);
    push_signature(tag_guid, tag_struct, 1'b0);
    push_noise(int'(GUID_SKIP));
    push_word_le(w0);
    push_word_le(w1);
    push_word_le(w2);
    push_word_le(w3);
  endtask

  // name record with its terminator; chars are random
  task automatic push_name_record(input logic [31:0] len);
    push_signature(tag_name, tag_string, 1'b0);
    push_noise(int'(NAME_SKIP));
    push_word_le(len);
    if (len > 32'd1) push_noise(int'(len) - 1);
    push_byte(8'($urandom));
  endtask

  function automatic logic [31:0] pick_name_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 32'($urandom_range(0, 8));
    if (r < 19) return 32'($urandom_range(9, 40));
    return 32'($urandom_range(41, 300));
  endfunction

  task automatic push_random_phase(input int budget);
    int start;
    int pick;
    start = pushed_total;
    while (pushed_total - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_guid_record($urandom(), $urandom(), $urandom(), $urandom());
      end else if (pick < 80) begin
        push_name_record(pick_name_length());
      end else if (pick < 90) begin
        // damaged signature followed by junk
        if (pick[0]) push_signature(tag_guid, tag_struct, 1'b1);
        else push_signature(tag_name, tag_string, 1'b1);
        push_noise($urandom_range(0, 20));
      end else begin
        push_noise($urandom_range(1, 8));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // register writes and phase boundaries
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic write_tags(input logic [7:0] g, input logic [7:0] s,
                            input logic [7:0] n, input logic [7:0] t);
    write_reg(REG_GUID_TAG, g);
    write_reg(REG_STRUCT_TAG, s);
    write_reg(REG_NAME_TAG, n);
    write_reg(REG_STRING_TAG, t);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (stream_bytes.size() != 0 || stream_if.valid || expected_records.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] ta;
    logic [7:0] tb_;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    rst               = 1'b1;
    pushed_total      = 0;
    check_errors      = 0;
    tag_guid   = '0;
    tag_struct = '0;
    tag_name   = '0;
    tag_string = '0;
    scan_phase = PH_HEADER;
    scan_count = '0;
    for (int i = 0; i < WinLen; i++) scan_window[i] = '0;
    name_left = '0;
    word_acc  = '0;
    word_pos  = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset tags: both signatures all zero, identifier must win the tie
    push_byte(8'h00);
    push_byte(8'hff);
    push_noise(2);
    push_guid_record(32'hffff_ffff, 32'h0000_0000, 32'h8000_0001, $urandom());
    wait_drained();

    // extreme tags; zero, one and short name lengths
    write_tags(8'hff, 8'h00, 8'h00, 8'hff);
    push_name_record(32'd0);
    push_name_record(32'd1);
    push_name_record(32'd3);
    push_guid_record($urandom(), $urandom(), $urandom(), $urandom());
    push_random_phase(PhaseBudget);
    wait_drained();

    // random tags
    write_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    push_random_phase(PhaseBudget);
    wait_drained();

    // identical signatures
    ta  = 8'($urandom);
    tb_ = 8'($urandom);
    write_tags(ta, tb_, ta, tb_);
    push_random_phase(PhaseBudget);
    wait_drained();

    // opposite extremes
    write_tags(8'h00, 8'hff, 8'hff, 8'h00);
    push_random_phase(PhaseBudget);
    wait_drained();

    // unused indexes must leave the tags alone
    write_tags(8'($urandom_range(1, 127)), 8'($urandom), 8'($urandom_range(128, 255)),
               8'($urandom));
    for (int i = 0; i < 4; i++) write_reg(RegFirstUnused + 3'(i), 8'($urandom));
    push_random_phase(PhaseBudget);
    // huge length: chars keep coming until the stream ends
    push_signature(tag_name, tag_string, 1'b0);
    push_noise(int'(NAME_SKIP));
    push_noise(3);
    push_byte(8'($urandom_range(128, 255)));
    push_noise(60);
    wait_drained();

    if (check_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // byte driver: bursts with gaps, valid held until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      stream_if.valid   <= 1'b0;
      stream_if.in_byte <= '0;
      bytes_accepted    <= 0;
      gap_left          = 0;
      burst_left        = 0;
    end else begin
      if (stream_if.valid && stream_if.ready) begin
        step_scanner(stream_if.in_byte);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!stream_if.valid || stream_if.ready) begin
        if (gap_left > 0 || stream_bytes.size() == 0) begin
          stream_if.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          stream_if.valid   <= 1'b1;
          stream_if.in_byte <= stream_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready pattern with one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rec_if.ready <= 1'b0;
      stall_left   = 0;
      run_left     = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
    end else if (hold_left > 0) begin
      rec_if.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && bytes_accepted >= HoldAfterBytes) begin
      rec_if.ready <= 1'b0;
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
    end else if (stall_left > 0) begin
      rec_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rec_if.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
        stall_left = $urandom_range(1, 5);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // record checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rec_if.valid && rec_if.ready) begin
      got_rec = '{rec_if.kind, rec_if.value, rec_if.word_index, rec_if.last};
      if (expected_records.size() == 0) begin
        $error("unexpected record: kind %0d value %h word_index %0d last %0b",
               got_rec.kind, got_rec.value, got_rec.word_index, got_rec.last);
        check_errors++;
      end else begin
        want_rec = expected_records.pop_front();
        if (got_rec.kind !== want_rec.kind) begin
          $error("kind: expected %0d, got %0d", want_rec.kind, got_rec.kind);
          check_errors++;
        end
        if (got_rec.value !== want_rec.value) begin
          $error("value: expected %h, got %h", want_rec.value, got_rec.value);
          check_errors++;
        end
        if (got_rec.word_index !== want_rec.word_index) begin
          $error("word_index: expected %0d, got %0d", want_rec.word_index,
                 got_rec.word_index);
          check_errors++;
        end
        if (got_rec.last !== want_rec.last) begin
          $error("last: expected %0b, got %0b", want_rec.last, got_rec.last);
          check_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles with no request taken on any channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((stream_if.valid && stream_if.ready) || (rec_if.valid && rec_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
